/* rtl/core/slir_pkg.sv */
// Shared types, constants and helpers for the slope-intercept line rasteriser.
package slir_pkg;

   // Screen geometry: coordinates are fixed at six bits by the interface
   localparam int SCREEN_SIZE = 64;
   localparam int COORD_W     = 6;

   // Restoring divider: one quotient bit per step
   localparam int DIV_STEPS   = COORD_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Signed width of the per-column y step (quotient plus carry and sign)
   localparam int STEP_W      = COORD_W + 2;

   localparam logic [COORD_W:0] COORD_MAX = (COORD_W + 1)'(SCREEN_SIZE - 1);

   // Controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_SETUP  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic setup;
      logic advance;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic x_mode;
      logic last;
   } status_type;

   // Saturate a coordinate to the last addressable row or column
   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      logic [COORD_W:0] v_ext;
      v_ext = {1'b0, v};
      return (v_ext > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : v;
   endfunction

endpackage

/* rtl/core/slir_ctrl.sv */
// Controller state machine: sequences load, slope division, setup and point emission.
module slir_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  slir_pkg::status_type   status,
   output slir_pkg::cmd_type      cmd
);

   slir_pkg::state_type                 state_ff, state_in;
   logic [slir_pkg::DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;

   // Decide the next state and the commands for this cycle
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         slir_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               div_cnt_in = '0;
               state_in   = status.x_mode ? slir_pkg::ST_DIVIDE : slir_pkg::ST_EMIT;
            end
         end
         slir_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == slir_pkg::DIV_CNT_W'(slir_pkg::DIV_STEPS - 1)) begin
               state_in = slir_pkg::ST_SETUP;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         slir_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = slir_pkg::ST_EMIT;
         end
         slir_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = slir_pkg::ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = slir_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold state and divider count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= slir_pkg::ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

/* rtl/core/slir_datapath.sv */
// Datapath: endpoint ordering, restoring slope divider and incremental point stepping.
module slir_datapath (
   input  logic                          clock,
   input  logic [slir_pkg::COORD_W-1:0]  req_x_start,
   input  logic [slir_pkg::COORD_W-1:0]  req_y_start,
   input  logic [slir_pkg::COORD_W-1:0]  req_x_end,
   input  logic [slir_pkg::COORD_W-1:0]  req_y_end,
   input  slir_pkg::cmd_type             cmd,
   output slir_pkg::status_type          status,
   output logic [slir_pkg::COORD_W-1:0]  rsp_point_x,
   output logic [slir_pkg::COORD_W-1:0]  rsp_point_y,
   output logic                          rsp_last_point
);

   localparam int W  = slir_pkg::COORD_W;
   localparam int SW = slir_pkg::STEP_W;

   logic [W-1:0]          xa, ya, xb, yb;
   logic                  swap, in_x_mode;
   logic [W-1:0]          x1, y1, x2, y2, y_lo, y_hi;

   logic [W-1:0]          x_ff, x_in, y_ff, y_in;
   logic [W-1:0]          x_end_ff, x_end_in, y_end_ff, y_end_in;
   logic [W-1:0]          dx_ff, dx_in;
   logic                  dy_neg_ff, dy_neg_in;
   logic                  x_mode_ff, x_mode_in;
   logic [W-1:0]          rem_ff, rem_in, quo_ff, quo_in;
   logic signed [SW-1:0]  q_step_ff, q_step_in;
   logic [W-1:0]          r_step_ff, r_step_in;
   logic [W-1:0]          frac_ff, frac_in;

   logic [W:0]            rem_sh, rem_sub;
   logic                  fits;
   logic signed [SW-1:0]  quo_ext;
   logic [W:0]            frac_sum, frac_sub;
   logic                  carry;
   logic signed [SW-1:0]  y_sum;

   // Saturate and order the endpoints of the incoming item
   always_comb begin
      xa        = slir_pkg::clamp_coord(req_x_start);
      ya        = slir_pkg::clamp_coord(req_y_start);
      xb        = slir_pkg::clamp_coord(req_x_end);
      yb        = slir_pkg::clamp_coord(req_y_end);
      in_x_mode = (xa != xb);
      swap      = (xb < xa);
      x1        = swap ? xb : xa;
      y1        = swap ? yb : ya;
      x2        = swap ? xa : xb;
      y2        = swap ? ya : yb;
      y_lo      = (yb < ya) ? yb : ya;
      y_hi      = (yb < ya) ? ya : yb;
   end

   // Divider step: shift in one dividend bit, subtract where it fits
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      fits    = (rem_sh >= {1'b0, dx_ff});
      rem_sub = rem_sh - {1'b0, dx_ff};
      quo_ext = $signed({2'b00, quo_ff});
   end

   // Column step: accumulate the remainder, carry one row when it wraps
   always_comb begin
      frac_sum = {1'b0, frac_ff} + {1'b0, r_step_ff};
      carry    = (frac_sum >= {1'b0, dx_ff});
      frac_sub = frac_sum - {1'b0, dx_ff};
      y_sum    = $signed({2'b00, y_ff}) + q_step_ff + $signed({{(SW-1){1'b0}}, carry});
   end

   // Next values of the datapath registers
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      x_end_in  = x_end_ff;
      y_end_in  = y_end_ff;
      dx_in     = dx_ff;
      dy_neg_in = dy_neg_ff;
      x_mode_in = x_mode_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      q_step_in = q_step_ff;
      r_step_in = r_step_ff;
      frac_in   = frac_ff;
      priority if (cmd.load) begin
         x_mode_in = in_x_mode;
         x_in      = in_x_mode ? x1 : xa;
         y_in      = in_x_mode ? y1 : y_lo;
         x_end_in  = x2;
         y_end_in  = y_hi;
         dx_in     = x2 - x1;
         dy_neg_in = (y2 < y1);
         quo_in    = (y2 < y1) ? (y1 - y2) : (y2 - y1);
         rem_in    = '0;
         frac_in   = '0;
      end else if (cmd.div_step) begin
         rem_in = fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
      end else if (cmd.setup) begin
         // Floor division: a negative slope with a remainder rounds down one more
         if (dy_neg_ff && (rem_ff != '0)) begin
            q_step_in = -(quo_ext + SW'(1));
            r_step_in = dx_ff - rem_ff;
         end else if (dy_neg_ff) begin
            q_step_in = -quo_ext;
            r_step_in = '0;
         end else begin
            q_step_in = quo_ext;
            r_step_in = rem_ff;
         end
      end else if (cmd.advance) begin
         if (x_mode_ff) begin
            x_in    = x_ff + 1'b1;
            y_in    = y_sum[W-1:0];
            frac_in = carry ? frac_sub[W-1:0] : frac_sum[W-1:0];
         end else begin
            y_in = y_ff + 1'b1;
         end
      end else begin
         x_in = x_ff;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      x_end_ff  <= x_end_in;
      y_end_ff  <= y_end_in;
      dx_ff     <= dx_in;
      dy_neg_ff <= dy_neg_in;
      x_mode_ff <= x_mode_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      q_step_ff <= q_step_in;
      r_step_ff <= r_step_in;
      frac_ff   <= frac_in;
   end

   // Drive the current point and the status back to the controller
   always_comb begin
      status.x_mode  = in_x_mode;
      status.last    = x_mode_ff ? (x_ff == x_end_ff) : (y_ff == y_end_ff);
      rsp_point_x    = x_ff;
      rsp_point_y    = y_ff;
      rsp_last_point = status.last;
   end

endmodule

/* rtl/core/slope_intercept_line_rasterizer.sv */
// Top level of the slope-intercept line rasteriser: controller plus datapath.
//
// Usage:
//   req_ channel: one item carries two endpoints (x_start, y_start, x_end,
//   y_end), six bits each, saturated to the last screen row/column.
//   rsp_ channel: one item per plotted point (point_x, point_y), with
//   last_point high on the final point of the line.
//   Lines with distinct x step x upward from the lower x, with
//   y = floor(y1 + dy*(x-x1)/dx); lines with equal x step y upward.
// Sequencing:
//   An item is taken only when the block is idle. A line with distinct x
//   is loaded, passes through the restoring slope divider (one quotient
//   bit per cycle) and a setup step, then emits one point per cycle while
//   rsp_ready is high. A line with equal x skips the divider and the setup
//   step and goes straight from load to emission.
//   The point registers drive the rsp_ channel directly; while rsp_ready is
//   low the current point holds and stepping stops.
// Reset: synchronous, active high; returns the controller to idle and
//   drops any line in progress.
module slope_intercept_line_rasterizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [slir_pkg::COORD_W-1:0]  req_x_start,
   input  logic [slir_pkg::COORD_W-1:0]  req_y_start,
   input  logic [slir_pkg::COORD_W-1:0]  req_x_end,
   input  logic [slir_pkg::COORD_W-1:0]  req_y_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [slir_pkg::COORD_W-1:0]  rsp_point_x,
   output logic [slir_pkg::COORD_W-1:0]  rsp_point_y,
   output logic                          rsp_last_point
);

   slir_pkg::cmd_type     cmd;
   slir_pkg::status_type  status;

   // Sequence the work of one line
   slir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Divide the slope and step the points
   slir_datapath u_datapath (
      .clock          (clock),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .cmd            (cmd),
      .status         (status),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

endmodule

/* rtl/core/slir_checker.sv */
// Port-level checker for the line rasteriser, bound to the top level.
module slir_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [slir_pkg::COORD_W-1:0]  rsp_point_x,
   input logic [slir_pkg::COORD_W-1:0]  rsp_point_y,
   input logic                          rsp_last_point
);

   // A stalled point holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_point_x)
                                     && $stable(rsp_point_y) && $stable(rsp_last_point)))
      else $error("rsp item changed while stalled");

   // No new line is taken while points are still being emitted
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req taken while a line is in flight");

   // An accepted line closes the request side on the next cycle
   a_req_close: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready stayed high after an accepted item");

   // The last point ends the output of the line
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_point) |=> !rsp_valid)
      else $error("rsp_valid after the last point");

   // Points of one line follow without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_point) |=> rsp_valid)
      else $error("gap inside a line");

endmodule

bind slope_intercept_line_rasterizer slir_checker u_slir_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_point_x    (rsp_point_x),
   .rsp_point_y    (rsp_point_y),
   .rsp_last_point (rsp_last_point)
);
